### hdl/shr_pkg.sv
// Package for the single-wire humidity sensor reader.
// Holds widths, configuration reset values, phase codes and the shared structs.
// Depends on nothing.
package shr_pkg;

  localparam int unsigned MaxEdges = 85;

  localparam logic [19:0] PrehighReset  = 20'd500000;
  localparam logic [19:0] StartLowReset = 20'd20000;
  localparam logic [15:0] ThresholdReset = 16'd200;
  localparam logic [15:0] TimeoutReset   = 16'd1000;

  localparam logic [5:0] BitsStored = 6'd40;
  localparam logic [5:0] BitsMax    = 6'd63;
  localparam logic [5:0] BitsForSum = 6'd39;
  localparam logic [7:0] FirstDataEdge = 8'd3;

  typedef enum logic [1:0] {
    CfgPrehigh   = 2'd0,
    CfgStartLow  = 2'd1,
    CfgThreshold = 2'd2,
    CfgTimeout   = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PhIdle    = 5'b00001,
    PhHigh    = 5'b00010,
    PhLow     = 5'b00100,
    PhWait    = 5'b01000,
    PhMeasure = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [19:0] prehigh_ticks;
    logic [19:0] start_low_ticks;
    logic [15:0] bit_threshold;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic       drive_enable;
    logic       drive_level;
    logic       done_res;
    logic       checksum_ok;
    logic       timed_out;
    logic [7:0] humidity_whole;
    logic [7:0] humidity_fraction;
    logic [7:0] temperature_whole;
    logic [7:0] temperature_fraction;
    logic [7:0] check_byte;
    logic [5:0] bits_received;
  } res_t;

  function automatic logic [19:0] at_least_one(logic [19:0] v);
    return (v == 20'd0) ? 20'd1 : v;
  endfunction

endpackage

### hdl/shr_if.sv
// Valid/ready channel interfaces for the sensor reader: input ticks and results.
// Standalone; payload widths follow the item definitions.
interface shr_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic pin_level;

  modport source (output valid, output kind, output pin_level, input ready);
  modport sink   (input valid, input kind, input pin_level, output ready);
endinterface

interface shr_out_if;
  logic       valid;
  logic       ready;
  logic       drive_enable;
  logic       drive_level;
  logic       done_res;
  logic       checksum_ok;
  logic       timed_out;
  logic [7:0] humidity_whole;
  logic [7:0] humidity_fraction;
  logic [7:0] temperature_whole;
  logic [7:0] temperature_fraction;
  logic [7:0] check_byte;
  logic [5:0] bits_received;

  modport source (
    output valid, output drive_enable, output drive_level, output done_res,
    output checksum_ok, output timed_out, output humidity_whole,
    output humidity_fraction, output temperature_whole, output temperature_fraction,
    output check_byte, output bits_received, input ready
  );
  modport sink (
    input valid, input drive_enable, input drive_level, input done_res,
    input checksum_ok, input timed_out, input humidity_whole,
    input humidity_fraction, input temperature_whole, input temperature_fraction,
    input check_byte, input bits_received, output ready
  );
endinterface

### hdl/shr_core.sv
// Read sequencer state and per-tick update logic for the sensor reader.
// Depends on shr_pkg for phase codes, config and result structs.
module shr_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          kind_i,
  input  logic          pin_level_i,
  input  shr_pkg::cfg_t cfg_i,
  output shr_pkg::res_t res_o
);

  shr_pkg::phase_e phase_q, phase_d;
  logic [19:0] run_cnt_q, run_cnt_d;
  logic        prev_lvl_q, prev_lvl_d;
  logic [7:0]  trans_q, trans_d;
  logic [5:0]  bit_idx_q, bit_idx_d;
  logic [7:0]  bytes_q [5];
  logic [7:0]  bytes_d [5];

  logic [19:0] run_inc;
  logic [19:0] limit;
  logic [7:0]  trans_inc;
  logic [7:0]  sum;
  logic        done, tmo;

  assign run_inc   = run_cnt_q + 20'd1;
  assign trans_inc = trans_q + 8'd1;
  assign limit     = shr_pkg::at_least_one({4'd0, cfg_i.timeout_ticks});

  always_comb begin
    phase_d    = phase_q;
    run_cnt_d  = run_cnt_q;
    prev_lvl_d = prev_lvl_q;
    trans_d    = trans_q;
    bit_idx_d  = bit_idx_q;
    bytes_d    = bytes_q;
    done       = 1'b0;
    tmo        = 1'b0;
    if (accept_i) begin
      if (kind_i) begin
        phase_d    = shr_pkg::PhHigh;
        run_cnt_d  = 20'd0;
        prev_lvl_d = 1'b1;
        trans_d    = 8'd0;
        bit_idx_d  = 6'd0;
        for (int i = 0; i < 5; i++) bytes_d[i] = 8'd0;
      end else begin
        case (phase_q)
          shr_pkg::PhHigh: begin
            run_cnt_d = run_inc;
            if (run_inc >= shr_pkg::at_least_one(cfg_i.prehigh_ticks)) begin
              phase_d   = shr_pkg::PhLow;
              run_cnt_d = 20'd0;
            end
          end
          shr_pkg::PhLow: begin
            run_cnt_d = run_inc;
            if (run_inc >= shr_pkg::at_least_one(cfg_i.start_low_ticks)) begin
              phase_d   = shr_pkg::PhWait;
              run_cnt_d = 20'd0;
            end
          end
          shr_pkg::PhWait: begin
            if (!pin_level_i) begin
              phase_d    = shr_pkg::PhMeasure;
              prev_lvl_d = 1'b0;
              run_cnt_d  = 20'd0;
              trans_d    = 8'd1;
              if (8'd1 >= 8'(shr_pkg::MaxEdges)) begin
                phase_d = shr_pkg::PhIdle;
                done    = 1'b1;
              end
            end else begin
              run_cnt_d = run_inc;
              if (run_inc >= limit) begin
                phase_d = shr_pkg::PhIdle;
                done    = 1'b1;
                tmo     = 1'b1;
              end
            end
          end
          shr_pkg::PhMeasure: begin
            if (pin_level_i == prev_lvl_q) begin
              run_cnt_d = run_inc;
              if (run_inc >= limit) begin
                phase_d = shr_pkg::PhIdle;
                done    = 1'b1;
                tmo     = 1'b1;
              end
            end else begin
              if (trans_q >= shr_pkg::FirstDataEdge && !trans_q[0]) begin
                if (bit_idx_q < shr_pkg::BitsStored) begin
                  bytes_d[bit_idx_q[5:3]] = {bytes_q[bit_idx_q[5:3]][6:0],
                                             run_cnt_q > {4'd0, cfg_i.bit_threshold}};
                end
                if (bit_idx_q < shr_pkg::BitsMax) bit_idx_d = bit_idx_q + 6'd1;
              end
              prev_lvl_d = pin_level_i;
              run_cnt_d  = 20'd0;
              trans_d    = trans_inc;
              if (trans_inc >= 8'(shr_pkg::MaxEdges) || trans_inc == 8'd0) begin
                phase_d = shr_pkg::PhIdle;
                done    = 1'b1;
              end
            end
          end
          default: phase_d = shr_pkg::PhIdle;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= shr_pkg::PhIdle;
      run_cnt_q  <= 20'd0;
      prev_lvl_q <= 1'b1;
      trans_q    <= 8'd0;
      bit_idx_q  <= 6'd0;
      for (int i = 0; i < 5; i++) bytes_q[i] <= 8'd0;
    end else begin
      phase_q    <= phase_d;
      run_cnt_q  <= run_cnt_d;
      prev_lvl_q <= prev_lvl_d;
      trans_q    <= trans_d;
      bit_idx_q  <= bit_idx_d;
      bytes_q    <= bytes_d;
    end
  end

  assign sum = bytes_d[0] + bytes_d[1] + bytes_d[2] + bytes_d[3];

  always_comb begin
    res_o.drive_enable         = (phase_d == shr_pkg::PhHigh) || (phase_d == shr_pkg::PhLow);
    res_o.drive_level          = (phase_d == shr_pkg::PhHigh);
    res_o.done_res             = done;
    res_o.checksum_ok          = (bit_idx_d >= shr_pkg::BitsForSum) && (bytes_d[4] == sum);
    res_o.timed_out            = tmo;
    res_o.humidity_whole       = bytes_d[0];
    res_o.humidity_fraction    = bytes_d[1];
    res_o.temperature_whole    = bytes_d[2];
    res_o.temperature_fraction = bytes_d[3];
    res_o.check_byte           = bytes_d[4];
    res_o.bits_received        = bit_idx_d;
  end

endmodule

### hdl/single_wire_humidity_sensor_reader.sv
// Top level of the single-wire humidity sensor reader.
// Depends on shr_pkg, shr_if (shr_in_if, shr_out_if) and shr_core.
//
//   channel   direction  contents
//   in_i      sink       kind, pin_level (one transaction per tick)
//   out_o     source     drive, flags, five bytes, bits_received
//   cfg_*     write      index 0..3, data up to 20 bits
//
// Each input transaction yields one result, registered and shown in the next
// cycle; one transaction per cycle is sustained while out_o.ready is high.
// in_i.ready drops only while a result waits and out_o.ready is low. Reset puts
// the sequencer idle, the bytes at zero and the config registers at their
// defaults.
module single_wire_humidity_sensor_reader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [19:0] cfg_data_i,
  shr_in_if.sink      in_i,
  shr_out_if.source   out_o
);

  shr_pkg::cfg_t cfg_q;
  shr_pkg::res_t res_d, res_q;
  logic          out_valid_q, out_valid_d;
  logic          accept;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prehigh_ticks   <= shr_pkg::PrehighReset;
      cfg_q.start_low_ticks <= shr_pkg::StartLowReset;
      cfg_q.bit_threshold   <= shr_pkg::ThresholdReset;
      cfg_q.timeout_ticks   <= shr_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        shr_pkg::CfgPrehigh:   cfg_q.prehigh_ticks   <= cfg_data_i;
        shr_pkg::CfgStartLow:  cfg_q.start_low_ticks <= cfg_data_i;
        shr_pkg::CfgThreshold: cfg_q.bit_threshold   <= cfg_data_i[15:0];
        shr_pkg::CfgTimeout:   cfg_q.timeout_ticks   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  shr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .kind_i      (in_i.kind),
    .pin_level_i (in_i.pin_level),
    .cfg_i       (cfg_q),
    .res_o       (res_d)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.drive_enable         = res_q.drive_enable;
  assign out_o.drive_level          = res_q.drive_level;
  assign out_o.done_res             = res_q.done_res;
  assign out_o.checksum_ok          = res_q.checksum_ok;
  assign out_o.timed_out            = res_q.timed_out;
  assign out_o.humidity_whole       = res_q.humidity_whole;
  assign out_o.humidity_fraction    = res_q.humidity_fraction;
  assign out_o.temperature_whole    = res_q.temperature_whole;
  assign out_o.temperature_fraction = res_q.temperature_fraction;
  assign out_o.check_byte           = res_q.check_byte;
  assign out_o.bits_received        = res_q.bits_received;

endmodule
